// ===== rtl/word_neighbor_matrix_builder_defines.svh =====
// Assertion macros for the word neighbor matrix builder.
// Included by the top level; no other dependencies.
`ifndef WORD_NEIGHBOR_MATRIX_BUILDER_DEFINES_SVH
`define WORD_NEIGHBOR_MATRIX_BUILDER_DEFINES_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: %m");
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: %m");
`else
`define ASSERT_IMPLY(name, clk, rst, ante, cons)
`define ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/wnmb_pkg.sv =====
// Shared constants, codes and helpers for the word neighbor matrix builder.
// No dependencies.
`timescale 1ns / 1ps
package wnmb_pkg;
   localparam int MAX_WORDS  = 32;
   localparam int MAX_CHARS  = 8;
   localparam int WORD_W     = 8 * MAX_CHARS;
   localparam int COUNT_W    = 8;
   localparam int CFG_LEN_W  = 4;
   localparam int LEN_W      = $clog2(MAX_CHARS + 1);
   localparam int IDX_W      = $clog2(MAX_WORDS);
   localparam int CNT_W      = $clog2(MAX_WORDS + 1);
   localparam int NBR_W      = 32;
   localparam int STATUS_W   = 2;
   localparam int STORE_W    = LEN_W + WORD_W;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [CFG_LEN_W-1:0]  WORD_LENGTH_RESET = 4'd4;
   localparam logic [CSR_ADDR_W-1:0] WORD_LENGTH_ADDR  = 2'd0;

   localparam logic [STATUS_W-1:0] ST_ADDED   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_BAD_LEN = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

   localparam logic KIND_ACK = 1'b0;
   localparam logic KIND_ROW = 1'b1;

   function automatic logic [WORD_W-1:0] char_mask(input logic [LEN_W-1:0] len);
      logic [WORD_W-1:0] m;
      m = '0;
      for (int k = 0; k < MAX_CHARS; k++) begin
         if (k < int'(len)) begin
            m[8*k +: 8] = 8'hFF;
         end
      end
      return m;
   endfunction
endpackage

// ===== rtl/wnmb_req_if.sv =====
// Input channel: one word per beat.
// Depends on wnmb_pkg.
`timescale 1ns / 1ps
interface wnmb_req_if;
   logic                          valid;
   logic                          ready;
   logic [wnmb_pkg::WORD_W-1:0]   word_chars;
   logic [wnmb_pkg::COUNT_W-1:0]  char_count;
   logic                          final_word;

   modport source (output valid, word_chars, char_count, final_word, input ready);
   modport sink   (input valid, word_chars, char_count, final_word, output ready);
endinterface

// ===== rtl/wnmb_rsp_if.sv =====
// Result channel: acknowledgements and adjacency rows.
// Depends on wnmb_pkg.
`timescale 1ns / 1ps
interface wnmb_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           result_kind;
   logic [wnmb_pkg::STATUS_W-1:0]  status;
   logic [wnmb_pkg::IDX_W-1:0]     entry_index;
   logic [wnmb_pkg::NBR_W-1:0]     neighbor_bits;
   logic                           run_end;

   modport source (output valid, result_kind, status, entry_index, neighbor_bits, run_end,
                   input ready);
   modport sink   (input valid, result_kind, status, entry_index, neighbor_bits, run_end,
                   output ready);
endinterface

// ===== rtl/word_neighbor_matrix_builder.sv =====
// Word neighbor matrix builder: word table, sequencer and one shared word comparator.
// The acknowledgement is registered and appears in the cycle after the input beat.
// Intake: words are taken only in idle while the result channel is free; a final word with
// N stored words then builds N rows, each a row read, a table read and compare per column, and a stalling emit.
// Reset (synchronous): word count cleared, word_length = 4, table contents kept.
// Depends on wnmb_pkg, wnmb_req_if, wnmb_rsp_if and the defines header.
`timescale 1ns / 1ps
`include "word_neighbor_matrix_builder_defines.svh"
module word_neighbor_matrix_builder (
   input  logic                               clock,
   input  logic                               reset,
   wnmb_req_if.sink                           req_beat,
   wnmb_rsp_if.source                         rsp_beat,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [wnmb_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [wnmb_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [wnmb_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready
);
   import wnmb_pkg::*;

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_ROW_RD  = 3'd1;
   localparam logic [2:0] S_ROW_LD  = 3'd2;
   localparam logic [2:0] S_COL_RD  = 3'd3;
   localparam logic [2:0] S_COL_CMP = 3'd4;
   localparam logic [2:0] S_EMIT    = 3'd5;

   logic [2:0]            state_ff, state_in;
   logic [CFG_LEN_W-1:0]  word_length_ff, word_length_in;
   logic [CNT_W-1:0]      total_ff, total_in;
   logic [IDX_W-1:0]      row_ff, row_in;
   logic [IDX_W-1:0]      col_ff, col_in;
   logic [STORE_W-1:0]    row_word_ff, row_word_in;
   logic [NBR_W-1:0]      nbr_ff, nbr_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_kind_ff, rsp_kind_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [IDX_W-1:0]      rsp_index_ff, rsp_index_in;
   logic [NBR_W-1:0]      rsp_bits_ff, rsp_bits_in;
   logic                  rsp_end_ff, rsp_end_in;

   logic [STORE_W-1:0]    store_mem [MAX_WORDS];
   logic [STORE_W-1:0]    rd_data_ff;
   logic [IDX_W-1:0]      rd_addr;
   logic                  wr_en;
   logic [STORE_W-1:0]    wr_data;

   logic                  out_free, req_fire, len_ok, table_full, csr_wr;
   logic [LEN_W-1:0]      count_len;
   logic [MAX_CHARS-1:0]  char_diff;
   logic                  col_hit, row_last, col_last;

   // CSR
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && (csr_paddr == WORD_LENGTH_ADDR);
   assign csr_prdata = (csr_paddr == WORD_LENGTH_ADDR) ?
                       CSR_DATA_W'(word_length_ff) : '0;
   assign word_length_in = csr_wr ? csr_pwdata[CFG_LEN_W-1:0] : word_length_ff;

   // word intake
   assign out_free       = !rsp_valid_ff || rsp_beat.ready;
   assign req_beat.ready = (state_ff == S_IDLE) && out_free;
   assign req_fire       = req_beat.valid && req_beat.ready;
   assign len_ok     = (word_length_ff != '0) &&
                       (word_length_ff <= CFG_LEN_W'(MAX_CHARS)) &&
                       (req_beat.char_count == COUNT_W'(word_length_ff));
   assign table_full = total_ff >= CNT_W'(MAX_WORDS);
   assign count_len  = LEN_W'(word_length_ff);
   assign wr_en      = req_fire && len_ok && !table_full;
   assign wr_data    = {count_len, req_beat.word_chars & char_mask(count_len)};

   // shared comparator: same length and exactly one differing character
   always_comb begin
      for (int k = 0; k < MAX_CHARS; k++) begin
         char_diff[k] = row_word_ff[8*k +: 8] != rd_data_ff[8*k +: 8];
      end
   end
   assign col_hit  = (row_word_ff[STORE_W-1 -: LEN_W] == rd_data_ff[STORE_W-1 -: LEN_W]) &&
                     $onehot(char_diff);
   assign row_last = (CNT_W'(row_ff) + CNT_W'(1)) == total_ff;
   assign col_last = (CNT_W'(col_ff) + CNT_W'(1)) == total_ff;
   assign rd_addr  = (state_ff == S_ROW_RD) ? row_ff : col_ff;

   always_comb begin
      state_in      = state_ff;
      total_in      = total_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      row_word_in   = row_word_ff;
      nbr_in        = nbr_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_beat.ready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_bits_in   = rsp_bits_ff;
      rsp_end_in    = rsp_end_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               total_in      = total_ff + CNT_W'(wr_en);
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = KIND_ACK;
               rsp_bits_in   = '0;
               rsp_index_in  = wr_en ? total_ff[IDX_W-1:0] : '0;
               rsp_status_in = !len_ok ? ST_BAD_LEN : (table_full ? ST_FULL : ST_ADDED);
               rsp_end_in    = !req_beat.final_word || (total_in == '0);
               row_in        = '0;
               if (req_beat.final_word && (total_in != '0)) begin
                  state_in = S_ROW_RD;
               end
            end
         end
         S_ROW_RD: begin
            state_in = S_ROW_LD;
         end
         S_ROW_LD: begin
            row_word_in = rd_data_ff;
            col_in      = '0;
            nbr_in      = '0;
            state_in    = S_COL_RD;
         end
         S_COL_RD: begin
            state_in = S_COL_CMP;
         end
         S_COL_CMP: begin
            nbr_in[col_ff] = col_hit;
            if (col_last) begin
               state_in = S_EMIT;
            end else begin
               col_in   = col_ff + IDX_W'(1);
               state_in = S_COL_RD;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = KIND_ROW;
               rsp_status_in = ST_ADDED;
               rsp_index_in  = row_ff;
               rsp_bits_in   = nbr_ff;
               rsp_end_in    = row_last;
               if (row_last) begin
                  state_in = S_IDLE;
               end else begin
                  row_in   = row_ff + IDX_W'(1);
                  state_in = S_ROW_RD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         word_length_ff <= WORD_LENGTH_RESET;
         total_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         word_length_ff <= word_length_in;
         total_ff       <= total_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff        <= row_in;
      col_ff        <= col_in;
      row_word_ff   <= row_word_in;
      nbr_ff        <= nbr_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_bits_ff   <= rsp_bits_in;
      rsp_end_ff    <= rsp_end_in;
   end

   // word table
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[total_ff[IDX_W-1:0]] <= wr_data;
      end
      rd_data_ff <= store_mem[rd_addr];
   end

   assign rsp_beat.valid         = rsp_valid_ff;
   assign rsp_beat.result_kind   = rsp_kind_ff;
   assign rsp_beat.status        = rsp_status_ff;
   assign rsp_beat.entry_index   = rsp_index_ff;
   assign rsp_beat.neighbor_bits = rsp_bits_ff;
   assign rsp_beat.run_end       = rsp_end_ff;

   `ASSERT_IMPLY(a_total_bound, clock, reset, 1'b1, total_ff <= CNT_W'(MAX_WORDS))
   `ASSERT_IMPLY(a_ready_idle, clock, reset, req_beat.ready, state_ff == S_IDLE)
   `ASSERT_NEXT(a_build_start, clock, reset, req_fire && req_beat.final_word && (total_in != '0), state_ff == S_ROW_RD)
   `ASSERT_IMPLY(a_row_index, clock, reset, rsp_valid_ff && (rsp_kind_ff == KIND_ROW), CNT_W'(rsp_index_ff) < total_ff)
endmodule
